// ===== hw/rtl/bmm_pkg.sv =====
`timescale 1ns / 1ps

package bmm_pkg;

    localparam int BYTE_W        = 8;
    localparam int WORK_RAM_DEPTH = 8192;
    localparam int CART_RAM_DEPTH = 32768;
    localparam int BANK_OFS_W    = 14;

    typedef struct packed {
        logic busy;
        logic done;
    } mod_status_t;

endpackage

// ===== hw/rtl/bmm_ram.sv =====
`timescale 1ns / 1ps

module bmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== hw/rtl/bmm_mod.sv =====
`timescale 1ns / 1ps

module bmm_mod (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [7:0]          dividend,
    input  logic [8:0]          divisor,
    output bmm_pkg::mod_status_t status,
    output logic [7:0]          remainder
);

    import bmm_pkg::*;

    logic       busy_reg, busy_next;
    logic       done_reg, done_next;
    logic [2:0] step_reg, step_next;
    logic [7:0] rem_reg, rem_next;
    logic [7:0] dvd_reg, dvd_next;
    logic [8:0] div_reg, div_next;
    logic [8:0] trial;

    assign trial = {rem_reg, dvd_reg[7]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = 3'd0;
            rem_next  = 8'd0;
            dvd_next  = dividend;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            // shift in one dividend bit, subtract where it fits
            if (trial >= div_reg)
            begin
                rem_next = 8'(trial - div_reg);
            end
            else
            begin
                rem_next = trial[7:0];
            end
            dvd_next  = {dvd_reg[6:0], 1'b0};
            step_next = step_reg + 3'd1;
            if (step_reg == 3'd7)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        div_reg <= div_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign remainder   = rem_reg;

endmodule

// ===== hw/rtl/banked_memory_mapper.sv =====
`timescale 1ns / 1ps
// A read result passes from a single-ported memory, read at acceptance, into the output register
// once the output is not stalled; no new item is accepted before that.
// A write to 0xFFFD-0xFFFF or to rom_bank_count reduces the three bank registers modulo the
// bank count, capped at ROM_BANKS, in a shared bit-serial unit; no item is accepted meanwhile.
// Reset: a clearing pass sets all of cartridge RAM to 0xFF and work RAM to 0;
// no item is accepted meanwhile. ROM contents are kept.

module banked_memory_mapper #(
    parameter int ROM_BANKS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [15:0] address,
    input  logic [7:0]  write_data,
    input  logic [18:0] rom_offset,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data
);

    import bmm_pkg::*;

    localparam int BANK_W    = (ROM_BANKS > 1) ? $clog2(ROM_BANKS) : 1;
    localparam int ROM_DEPTH = ROM_BANKS * 16384;
    localparam int ROM_AW    = $clog2(ROM_DEPTH);
    localparam logic [31:0] ROM_BYTES = 32'(ROM_DEPTH);
    localparam int CLR_W     = $clog2(CART_RAM_DEPTH);
    localparam int WORK_AW   = $clog2(WORK_RAM_DEPTH);

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_LOAD  = 2'd2;

    localparam logic REG_ROM_BANK_COUNT = 1'b0;

    localparam logic [15:0] ADDR_FIXED_END = 16'h0400;
    localparam logic [15:0] ADDR_WIN1      = 16'h4000;
    localparam logic [15:0] ADDR_WIN2      = 16'h8000;
    localparam logic [15:0] ADDR_WORK      = 16'hC000;
    localparam logic [15:0] ADDR_MAP_CTRL  = 16'hFFFC;
    localparam logic [15:0] ADDR_MAP_BANK0 = 16'hFFFD;
    localparam logic [15:0] ADDR_MAP_BANK1 = 16'hFFFE;
    localparam logic [15:0] ADDR_MAP_BANK2 = 16'hFFFF;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RESP = 2'b10
    } state_t;

    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_ROM,
        SRC_CART,
        SRC_WORK
    } src_t;

    state_t state_reg, state_next;
    src_t   src_reg, src_next;

    logic [5:0]       rom_bank_count_reg;
    logic [7:0]       window_bank_reg [3];
    logic [BANK_W-1:0] eff_bank_reg [3];
    logic             cart_en_reg;
    logic             cart_half_reg;
    logic             no_rom_reg;
    logic             clearing_reg;
    logic [CLR_W-1:0] clr_cnt_reg;
    logic             dirty_reg;
    logic             remap_reg;
    logic [1:0]       remap_idx_reg;
    logic             out_valid_reg;
    logic [7:0]       read_data_reg;
    logic [15:0]      addr_hold_reg;

    logic             cfg_wr;
    logic             accept;
    logic [8:0]       count_eff;
    logic             mapper_bank_wr;
    logic             mod_start;
    logic             mod_first;
    logic [1:0]       mod_idx;
    logic [7:0]       mod_rem;
    mod_status_t      mod_status;
    logic             in_cart_win;
    logic [BANK_W-1:0] sel_bank;
    logic             load_ok;
    logic             resp_move;
    logic [15:0]      mem_address;

    logic             rom_we;
    logic [ROM_AW-1:0] rom_addr;
    logic [7:0]       rom_rdata;
    logic             cart_we;
    logic [CLR_W-1:0] cart_addr;
    logic [7:0]       cart_wdata;
    logic [7:0]       cart_rdata;
    logic             work_we;
    logic [WORK_AW-1:0] work_addr;
    logic [7:0]       work_wdata;
    logic [7:0]       work_rdata;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ROM_BANK_COUNT);
    assign prdata = (paddr[2] == REG_ROM_BANK_COUNT) ? 32'(rom_bank_count_reg) : 32'd0;

    assign count_eff = (9'(rom_bank_count_reg) > 9'(ROM_BANKS)) ? 9'(ROM_BANKS)
                                                                : 9'(rom_bank_count_reg);

    assign in_stall = !((state_reg == S_IDLE) && !clearing_reg && !dirty_reg && !remap_reg);
    assign accept   = in_valid && !in_stall;

    // hold the accepted item's address on the memories while its result waits
    assign mem_address = (state_reg == S_RESP) ? addr_hold_reg : address;

    // address decode
    assign in_cart_win = (address >= ADDR_WIN2) && (address < ADDR_WORK);
    assign load_ok     = 32'(rom_offset) < ROM_BYTES;

    always_comb
    begin
        priority if (mem_address < ADDR_FIXED_END)
        begin
            sel_bank = '0;
        end
        else if (mem_address < ADDR_WIN1)
        begin
            sel_bank = eff_bank_reg[0];
        end
        else if (mem_address < ADDR_WIN2)
        begin
            sel_bank = eff_bank_reg[1];
        end
        else
        begin
            sel_bank = eff_bank_reg[2];
        end
    end

    always_comb
    begin
        src_next = src_reg;
        if (accept)
        begin
            priority if (kind != KIND_READ)
            begin
                src_next = SRC_NONE;
            end
            else if (address < ADDR_WIN2)
            begin
                src_next = SRC_ROM;
            end
            else if (address < ADDR_WORK)
            begin
                src_next = cart_en_reg ? SRC_CART : SRC_ROM;
            end
            else
            begin
                src_next = SRC_WORK;
            end
        end
    end

    // memory ports
    assign rom_we   = accept && (kind == KIND_LOAD) && load_ok;
    assign rom_addr = rom_we ? ROM_AW'(rom_offset)
                             : ROM_AW'({sel_bank, mem_address[BANK_OFS_W-1:0]});

    always_comb
    begin
        if (clearing_reg)
        begin
            cart_we    = 1'b1;
            cart_addr  = clr_cnt_reg;
            cart_wdata = 8'hFF;
            work_we    = 1'b1;
            work_addr  = clr_cnt_reg[WORK_AW-1:0];
            work_wdata = 8'h00;
        end
        else
        begin
            cart_we    = accept && (kind == KIND_WRITE) && in_cart_win && cart_en_reg;
            cart_addr  = {cart_half_reg, mem_address[BANK_OFS_W-1:0]};
            cart_wdata = write_data;
            work_we    = accept && (kind == KIND_WRITE) && (address >= ADDR_WORK);
            work_addr  = mem_address[WORK_AW-1:0];
            work_wdata = write_data;
        end
    end

    bmm_ram #(.WIDTH(BYTE_W), .DEPTH(ROM_DEPTH)) u_rom (
        .clk   (clk),
        .we    (rom_we),
        .addr  (rom_addr),
        .wdata (write_data),
        .rdata (rom_rdata)
    );

    bmm_ram #(.WIDTH(BYTE_W), .DEPTH(CART_RAM_DEPTH)) u_cart_ram (
        .clk   (clk),
        .we    (cart_we),
        .addr  (cart_addr),
        .wdata (cart_wdata),
        .rdata (cart_rdata)
    );

    bmm_ram #(.WIDTH(BYTE_W), .DEPTH(WORK_RAM_DEPTH)) u_work_ram (
        .clk   (clk),
        .we    (work_we),
        .addr  (work_addr),
        .wdata (work_wdata),
        .rdata (work_rdata)
    );

    // bank reduction sequencer
    assign mapper_bank_wr = work_we && !clearing_reg &&
                            ((address == ADDR_MAP_BANK0) || (address == ADDR_MAP_BANK1) ||
                             (address == ADDR_MAP_BANK2));
    assign mod_first = !remap_reg && dirty_reg;
    assign mod_start = mod_first || (mod_status.done && (remap_idx_reg != 2'd2));
    assign mod_idx   = mod_first ? 2'd0 : remap_idx_reg + 2'd1;

    bmm_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (window_bank_reg[mod_idx]),
        .divisor   (count_eff),
        .status    (mod_status),
        .remainder (mod_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dirty_reg     <= 1'b1;
            remap_reg     <= 1'b0;
            remap_idx_reg <= 2'd0;
        end
        else
        begin
            if (cfg_wr || mapper_bank_wr)
            begin
                dirty_reg <= 1'b1;
            end
            else if (mod_first)
            begin
                dirty_reg <= 1'b0;
            end
            if (mod_start)
            begin
                remap_reg     <= 1'b1;
                remap_idx_reg <= mod_idx;
            end
            else if (mod_status.done)
            begin
                remap_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mod_status.done)
        begin
            eff_bank_reg[remap_idx_reg] <= mod_rem[BANK_W-1:0];
        end
    end

    // mapper registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_bank_count_reg <= 6'd0;
            window_bank_reg[0] <= 8'd0;
            window_bank_reg[1] <= 8'd1;
            window_bank_reg[2] <= 8'd2;
            cart_en_reg        <= 1'b0;
            cart_half_reg      <= 1'b0;
            clearing_reg       <= 1'b1;
            clr_cnt_reg        <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                rom_bank_count_reg <= pwdata[5:0];
            end
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg)
                begin
                    clearing_reg <= 1'b0;
                end
            end
            else if (work_we)
            begin
                unique case (address)
                    ADDR_MAP_CTRL:
                    begin
                        cart_half_reg <= write_data[2];
                        cart_en_reg   <= write_data[3];
                    end
                    ADDR_MAP_BANK0: window_bank_reg[0] <= write_data;
                    ADDR_MAP_BANK1: window_bank_reg[1] <= write_data;
                    ADDR_MAP_BANK2: window_bank_reg[2] <= write_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // item control and output register
    assign resp_move = (state_reg == S_RESP) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept) state_next = S_RESP;
            S_RESP:  if (resp_move) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (resp_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg <= src_next;
        if (accept)
        begin
            no_rom_reg    <= (count_eff == 9'd0);
            addr_hold_reg <= address;
        end
        if (resp_move)
        begin
            unique case (src_reg)
                SRC_ROM:  read_data_reg <= no_rom_reg ? 8'hFF : rom_rdata;
                SRC_CART: read_data_reg <= cart_rdata;
                SRC_WORK: read_data_reg <= work_rdata;
                default:  read_data_reg <= 8'h00;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;

endmodule
